@@ hdl/url_pcc_pkg.sv @@
// Package with shared types, codes and character functions of the URL percent codec.
`timescale 1ns / 1ps

package url_pcc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAX_RES   = 3;
  localparam logic [7:0]  PCT_CHAR  = 8'h25;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_PCT  = 2'd1;
  localparam logic [1:0] PEND_HELD = 2'd2;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic [1:0]               count;
    logic [MAX_RES-1:0][7:0]  bytes;
    logic                     str_end;
  } res_t;

  typedef struct packed {
    res_t       res;
    logic [1:0] pending_nxt;
    byte_t      held_nxt;
  } xlate_t;

  function automatic logic is_reserved(input byte_t c);
    logic r;
    r = c inside {8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
                  8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F,
                  8'h40, 8'h5B, 8'h5D};
    return r;
  endfunction

  function automatic byte_t hex_upper(input logic [3:0] n);
    byte_t r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h37 + {4'd0, n};
    end
    return r;
  endfunction

  // Uppercase hex digit to nibble; ok is low for anything else.
  function automatic logic [4:0] hex_value(input byte_t c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

@@ hdl/url_pcc_ifs.sv @@
// Valid/ready channel interfaces for input, result and configuration transfers.
`timescale 1ns / 1ps

interface url_pcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;
  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface url_pcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       out_string_end;
  modport source (output valid, output out_byte, output run_last, output out_string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input out_string_end,
                  output ready);
endinterface

interface url_pcc_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

@@ hdl/url_percent_codec_core.sv @@
// Top level of the URL percent codec: mode and triple state, translation and result register.
// A result is registered and appears on out_ch in the cycle after the input transfer that causes it.
// One input per cycle while out_ch accepts and each input yields at most one result byte;
// an input that yields two or three bytes holds the input side while the single result
// register, which emits one byte per transfer, hands those bytes out.
// Reset (rst_n low, synchronous) selects encode mode, drops any held triple and empties
// the result register.
`timescale 1ns / 1ps

module url_percent_codec_core (
  input  logic          clk,
  input  logic          rst_n,
  url_pcc_in_if.sink    in_ch,
  url_pcc_out_if.source out_ch,
  url_pcc_cfg_if.sink   cfg_ch
);
  import url_pcc_pkg::*;

  // Mode register and the decoder's partial triple. pending_r tells how much of a
  // percent triple has arrived; held_r keeps its first hex digit.
  logic       mode_r;
  logic [1:0] pending_r, pending_nxt;
  byte_t      held_r, held_nxt;

  xlate_t xo;
  logic   can_load;
  logic   in_xfer;
  logic   cfg_xfer;

  // The configuration channel is always ready; the user must write only while the block is idle (not enforced here).
  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer     = cfg_ch.valid;

  // A new byte is taken whenever the result register is empty or is handing over its
  // final byte in this very cycle, so single-byte results stream at full rate.
  assign in_ch.ready = can_load;
  assign in_xfer     = in_ch.valid && can_load;

  url_pcc_xlate u_xlate (
    .mode    (mode_r),
    .pending (pending_r),
    .held    (held_r),
    .b       (in_ch.in_byte),
    .str_end (in_ch.string_end),
    .xo      (xo)
  );

  url_pcc_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_xfer),
    .res      (xo.res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // Triple state advances on an input transfer; a mode write drops anything held and takes priority.
  always_comb begin
    pending_nxt = pending_r;
    held_nxt    = held_r;
    if (cfg_xfer) begin
      pending_nxt = PEND_NONE;
      held_nxt    = '0;
    end else if (in_xfer) begin
      pending_nxt = xo.pending_nxt;
      held_nxt    = xo.held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ENCODE;
      pending_r <= PEND_NONE;
      held_r    <= '0;
    end else begin
      if (cfg_xfer) begin
        mode_r <= cfg_ch.mode;
      end
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

`ifndef SYNTH
  // The triple counter never reaches its unused code.
  a_pending_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("pending count reached unused code");

  // Encoding never starts a triple.
  a_encode_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ENCODE) |-> (pending_r == PEND_NONE))
    else $error("pending triple in encode mode");

  // After the final byte of a run leaves with no new load, the output goes empty.
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.run_last &&
     !(in_xfer && xo.res.count != 2'd0)) |=> !out_ch.valid)
    else $error("output still valid after final byte of a run");

  // The input side stalls while more than one byte waits in the result register.
  a_stall_on_expansion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.run_last) |-> !in_ch.ready)
    else $error("input accepted while an expansion drains");
`endif

endmodule

@@ hdl/url_pcc_xlate.sv @@
// Combinational translation of one input byte into up to three result bytes.
`timescale 1ns / 1ps

module url_pcc_xlate (
  input  logic               mode,
  input  logic [1:0]         pending,
  input  url_pcc_pkg::byte_t held,
  input  url_pcc_pkg::byte_t b,
  input  logic               str_end,
  output url_pcc_pkg::xlate_t xo
);
  import url_pcc_pkg::*;

  logic [4:0] hi_v;
  logic [4:0] lo_v;
  byte_t      code_char;
  logic       code_hit;

  assign hi_v      = hex_value(held);
  assign lo_v      = hex_value(b);
  assign code_char = {hi_v[3:0], lo_v[3:0]};
  assign code_hit  = hi_v[4] && lo_v[4] && is_reserved(code_char);

  always_comb begin
    xo             = '0;
    xo.pending_nxt = pending;
    xo.held_nxt    = held;
    xo.res.str_end = str_end;
    if (mode == MODE_ENCODE) begin
      if (is_reserved(b)) begin
        xo.res.count    = 2'd3;
        xo.res.bytes[0] = PCT_CHAR;
        xo.res.bytes[1] = hex_upper(b[7:4]);
        xo.res.bytes[2] = hex_upper(b[3:0]);
      end else begin
        xo.res.count    = 2'd1;
        xo.res.bytes[0] = b;
      end
    end else begin
      case (pending)
        PEND_PCT: begin
          if (str_end) begin
            xo.res.count    = 2'd2;
            xo.res.bytes[0] = PCT_CHAR;
            xo.res.bytes[1] = b;
            xo.pending_nxt  = PEND_NONE;
          end else begin
            xo.held_nxt    = b;
            xo.pending_nxt = PEND_HELD;
          end
        end
        PEND_HELD: begin
          if (code_hit) begin
            xo.res.count    = 2'd1;
            xo.res.bytes[0] = code_char;
          end else begin
            xo.res.count    = 2'd3;
            xo.res.bytes[0] = PCT_CHAR;
            xo.res.bytes[1] = held;
            xo.res.bytes[2] = b;
          end
          xo.pending_nxt = PEND_NONE;
          xo.held_nxt    = '0;
        end
        default: begin
          if (b == PCT_CHAR && !str_end) begin
            xo.pending_nxt = PEND_PCT;
          end else begin
            xo.res.count    = 2'd1;
            xo.res.bytes[0] = b;
            xo.pending_nxt  = PEND_NONE;
          end
        end
      endcase
    end
  end

endmodule

@@ hdl/url_pcc_emit.sv @@
// Result register that holds up to three bytes and shifts them out one per transfer.
`timescale 1ns / 1ps

module url_pcc_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  url_pcc_pkg::res_t   res,
  output logic                can_load,
  url_pcc_out_if.source       out_ch
);
  import url_pcc_pkg::*;

  logic [MAX_RES-1:0][7:0] bytes_r, bytes_nxt;
  logic [1:0]              remain_r, remain_nxt;
  logic                    end_r, end_nxt;
  logic                    out_xfer;

  assign out_xfer = out_ch.valid && out_ch.ready;
  assign can_load = (remain_r == 2'd0) || (remain_r == 2'd1 && out_ch.ready);

  assign out_ch.valid          = (remain_r != 2'd0);
  assign out_ch.out_byte       = bytes_r[0];
  assign out_ch.run_last       = (remain_r == 2'd1);
  assign out_ch.out_string_end = (remain_r == 2'd1) && end_r;

  always_comb begin
    bytes_nxt  = bytes_r;
    remain_nxt = remain_r;
    end_nxt    = end_r;
    if (load && res.count != 2'd0) begin
      bytes_nxt  = res.bytes;
      remain_nxt = res.count;
      end_nxt    = res.str_end;
    end else if (out_xfer) begin
      bytes_nxt  = {8'h00, bytes_r[MAX_RES-1:1]};
      remain_nxt = remain_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= 2'd0;
    end else begin
      remain_r <= remain_nxt;
    end
    bytes_r <= bytes_nxt;
    end_r   <= end_nxt;
  end

endmodule
